// File: sv/assert_macros.svh
// assertion helpers, clocked on clk and disabled during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge outside reset
`define MDSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// value must hold across a stalled output transaction
`define MDSC_ASSERT_HOLD(label, sig, msg) \
  label: assert property (@(posedge clk) disable iff (rst) \
    (out_valid && !out_ready) |=> $stable(sig)) else $error(msg);

`endif

// File: sv/mdsc_pkg.sv
`default_nettype none
package mdsc_pkg;

  localparam int CharWidth  = 8;
  localparam int CountWidth = 8;

  localparam logic [CharWidth-1:0] ChNul    = 8'h00;
  localparam logic [CharWidth-1:0] ChOpen   = 8'h28;
  localparam logic [CharWidth-1:0] ChClose  = 8'h29;
  localparam logic [CharWidth-1:0] ChVoid   = 8'h56;
  localparam logic [CharWidth-1:0] ChInt    = 8'h49;
  localparam logic [CharWidth-1:0] ChBool   = 8'h5A;
  localparam logic [CharWidth-1:0] ChShort  = 8'h53;
  localparam logic [CharWidth-1:0] ChByte   = 8'h42;
  localparam logic [CharWidth-1:0] ChChar   = 8'h43;
  localparam logic [CharWidth-1:0] ChFloat  = 8'h46;
  localparam logic [CharWidth-1:0] ChDouble = 8'h44;
  localparam logic [CharWidth-1:0] ChLong   = 8'h4A;
  localparam logic [CharWidth-1:0] ChClass  = 8'h4C;
  localparam logic [CharWidth-1:0] ChSemi   = 8'h3B;
  localparam logic [CharWidth-1:0] ChArray  = 8'h5B;

  typedef enum logic [3:0] {
    MODE_NORMAL = 4'b0001,
    MODE_CLASS  = 4'b0010,
    MODE_ARRAY  = 4'b0100,
    MODE_DONE   = 4'b1000
  } token_mode_t;

  typedef struct packed {
    logic                  in_return_part;
    token_mode_t           token_mode;
    logic [CountWidth-1:0] arg_count;
    logic [CountWidth-1:0] ret_count;
    logic [CharWidth-1:0]  ret_char;
    logic                  ret_char_taken;
    logic                  error_seen;
  } parse_state_t;

  typedef struct packed {
    logic [CountWidth-1:0] argument_words;
    logic [CountWidth-1:0] return_words;
    logic [CharWidth-1:0]  return_char;
    logic                  malformed;
  } result_t;

  localparam parse_state_t StateClear = '{
    in_return_part: 1'b0,
    token_mode:     MODE_NORMAL,
    arg_count:      '0,
    ret_count:      '0,
    ret_char:       '0,
    ret_char_taken: 1'b0,
    error_seen:     1'b0
  };

endpackage
`default_nettype wire

// File: sv/mdsc_decode.sv
`default_nettype none
module mdsc_decode import mdsc_pkg::*; #(
  parameter logic [CountWidth-1:0] WORD_LIMIT = 8'd255
) (
  input  parse_state_t         state,
  input  logic [CharWidth-1:0] descriptor_char,
  input  logic [1:0]           reference_slots,
  output parse_state_t         state_next,
  output logic                 is_end,
  output result_t              result
);

  logic                  add_en;
  logic [1:0]            add_words;
  logic [CountWidth-1:0] count_sel;
  logic [CountWidth:0]   count_sum;
  logic [CountWidth-1:0] count_new;
  logic                  count_sat;
  parse_state_t          upd;

  assign is_end    = (descriptor_char == ChNul);
  assign count_sel = state.in_return_part ? state.ret_count : state.arg_count;
  assign count_sum = {1'b0, count_sel} + {{(CountWidth-1){1'b0}}, add_words};
  assign count_sat = (count_sum > {1'b0, WORD_LIMIT});
  assign count_new = count_sat ? WORD_LIMIT : count_sum[CountWidth-1:0];

  always_comb begin
    add_en    = 1'b0;
    add_words = 2'd0;
    upd       = state;
    if (state.in_return_part && !state.ret_char_taken) begin
      upd.ret_char       = descriptor_char;
      upd.ret_char_taken = 1'b1;
    end
    case (state.token_mode)
      MODE_CLASS: begin
        if (descriptor_char == ChSemi) upd.token_mode = MODE_NORMAL;
      end
      MODE_ARRAY: begin
        if (descriptor_char == ChClass) upd.token_mode = MODE_CLASS;
        else if (descriptor_char != ChArray) upd.token_mode = MODE_NORMAL;
      end
      MODE_DONE: begin
      end
      MODE_NORMAL: begin
        case (descriptor_char)
          ChOpen, ChVoid: begin
          end
          ChClose: begin
            if (!state.in_return_part) upd.in_return_part = 1'b1;
            else upd.token_mode = MODE_DONE;
          end
          ChInt, ChBool, ChShort, ChByte, ChChar, ChFloat: begin
            add_en    = 1'b1;
            add_words = 2'd1;
          end
          ChDouble, ChLong: begin
            add_en    = 1'b1;
            add_words = 2'd2;
          end
          ChArray: begin
            add_en         = 1'b1;
            add_words      = reference_slots;
            upd.token_mode = MODE_ARRAY;
          end
          ChClass: begin
            add_en         = 1'b1;
            add_words      = reference_slots;
            upd.token_mode = MODE_CLASS;
          end
          default: begin
            upd.error_seen = 1'b1;
          end
        endcase
      end
      default: begin
        upd.token_mode = MODE_NORMAL;
      end
    endcase
    if (add_en) begin
      if (state.in_return_part) upd.ret_count = count_new;
      else upd.arg_count = count_new;
      if (count_sat) upd.error_seen = 1'b1;
    end
  end

  always_comb begin
    result.argument_words = state.arg_count;
    result.return_words   = state.ret_count;
    result.return_char    = (state.in_return_part && state.ret_char_taken) ?
                            state.ret_char : '0;
    result.malformed      = state.error_seen || !state.in_return_part ||
                            (state.token_mode == MODE_CLASS) ||
                            (state.token_mode == MODE_ARRAY);
    state_next            = is_end ? StateClear : upd;
  end

endmodule
`default_nettype wire

// File: sv/method_descriptor_slot_counter_core.sv
// Counts the argument and return words of a method type descriptor fed one
// byte per transaction, ending at a NUL byte, which yields one result with
// both word counts, the first return-type byte and a malformed flag. Each
// byte is decoded combinationally and folded into the registered parse state,
// so one byte is taken every clock. Only a NUL byte can stall: it waits while
// the result register still holds a result that has not been taken. Results
// are registered, appearing in the cycle after their NUL byte is accepted. COUNT_MAX
// caps both counts (at most 255); reference_slots sets the words per reference.
`default_nettype none
module method_descriptor_slot_counter_core import mdsc_pkg::*; #(
  parameter int COUNT_MAX = 255
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [1:0]            cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CharWidth-1:0]  descriptor_char,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CountWidth-1:0] argument_words,
  output logic [CountWidth-1:0] return_words,
  output logic [CharWidth-1:0]  return_char,
  output logic                  malformed
);

  localparam int                    WordLimitInt = (COUNT_MAX < 255) ? COUNT_MAX : 255;
  localparam logic [CountWidth-1:0] WordLimit    = WordLimitInt[CountWidth-1:0];

  logic [1:0]   reference_slots;
  parse_state_t state;
  parse_state_t state_next;
  logic         is_end;
  result_t      result;
  logic         in_accept;

  mdsc_decode #(
    .WORD_LIMIT(WordLimit)
  ) u_decode (
    .state          (state),
    .descriptor_char(descriptor_char),
    .reference_slots(reference_slots),
    .state_next     (state_next),
    .is_end         (is_end),
    .result         (result)
  );

  assign in_ready  = !out_valid || out_ready || !is_end;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_slots <= 2'd1;
    end else if (cfg_wr_en) begin
      reference_slots <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StateClear;
    end else if (in_accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && is_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && is_end) begin
      argument_words <= result.argument_words;
      return_words   <= result.return_words;
      return_char    <= result.return_char;
      malformed      <= result.malformed;
    end
  end

endmodule
`default_nettype wire

// File: sv/mdsc_checker.sv
`default_nettype none
`include "assert_macros.svh"
module mdsc_checker import mdsc_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic [CharWidth-1:0]  descriptor_char,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [CountWidth-1:0] argument_words,
  input logic [CountWidth-1:0] return_words,
  input logic [CharWidth-1:0]  return_char,
  input logic                  malformed
);

  logic                                end_accept;
  logic [2*CountWidth+CharWidth:0]     out_payload;

  assign end_accept  = in_valid && in_ready && (descriptor_char == ChNul);
  assign out_payload = {argument_words, return_words, return_char, malformed};

  // end byte transaction always produces a result next cycle
  `MDSC_ASSERT(a_end_gives_result, end_accept |=> out_valid, "result missing after end byte")

  // a new result only follows an accepted end byte
  `MDSC_ASSERT(a_result_from_end, $rose(out_valid) |-> $past(end_accept), "result without end byte")

  `MDSC_ASSERT(a_out_valid_holds, (out_valid && !out_ready) |=> out_valid, "result dropped while stalled")

  `MDSC_ASSERT_HOLD(a_result_hold, out_payload, "result changed while stalled")

endmodule

bind method_descriptor_slot_counter_core mdsc_checker u_mdsc_checker (.*);
`default_nettype wire
